>>> sv/stn_pkg.sv
// Shared types, codes and byte classifiers for the source tokenizer.
package stn_pkg;

  // Token kinds
  localparam logic [1:0] KIND_PUNCT  = 2'd0;
  localparam logic [1:0] KIND_IDENT  = 2'd1;
  localparam logic [1:0] KIND_NUMBER = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Punctuator codes
  localparam logic [3:0] PC_PLUS   = 4'd0;
  localparam logic [3:0] PC_MINUS  = 4'd1;
  localparam logic [3:0] PC_STAR   = 4'd2;
  localparam logic [3:0] PC_SLASH  = 4'd3;
  localparam logic [3:0] PC_LPAREN = 4'd4;
  localparam logic [3:0] PC_RPAREN = 4'd5;
  localparam logic [3:0] PC_EQ     = 4'd6;
  localparam logic [3:0] PC_LT     = 4'd7;
  localparam logic [3:0] PC_GT     = 4'd8;
  localparam logic [3:0] PC_NE     = 4'd9;
  localparam logic [3:0] PC_LE     = 4'd10;
  localparam logic [3:0] PC_GE     = 4'd11;
  localparam logic [3:0] PC_COMMA  = 4'd12;
  localparam logic [3:0] PC_DOT    = 4'd13;
  localparam logic [3:0] PC_SEMI   = 4'd14;
  localparam logic [3:0] PC_ASSIGN = 4'd15;

  // ASCII bytes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;

  localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

  // Result queue depth (two tokens per byte at most)
  localparam int QUEUE_DEPTH = 4;

  // Pending token kind
  typedef enum logic [5:0] {
    PK_NONE   = 6'b000001,
    PK_IDENT  = 6'b000010,
    PK_NUMBER = 6'b000100,
    PK_LT     = 6'b001000,
    PK_GT     = 6'b010000,
    PK_COLON  = 6'b100000
  } pend_kind_t;

  // Token fields other than offset and length
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  code;
    logic [30:0] value;
    logic        ovf;
    logic        last;
  } tok_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Single-byte punctuator lookup: {hit, code}
  function automatic logic [4:0] punct_lookup(input logic [7:0] c);
    logic [4:0] r;
    case (c)
      CH_PLUS:   r = {1'b1, PC_PLUS};
      CH_MINUS:  r = {1'b1, PC_MINUS};
      CH_STAR:   r = {1'b1, PC_STAR};
      CH_SLASH:  r = {1'b1, PC_SLASH};
      CH_LPAREN: r = {1'b1, PC_LPAREN};
      CH_RPAREN: r = {1'b1, PC_RPAREN};
      CH_EQ:     r = {1'b1, PC_EQ};
      CH_COMMA:  r = {1'b1, PC_COMMA};
      CH_DOT:    r = {1'b1, PC_DOT};
      CH_SEMI:   r = {1'b1, PC_SEMI};
      default:   r = {1'b0, PC_PLUS};
    endcase
    return r;
  endfunction

endpackage

>>> sv/stn_lexer.sv
// Lexer state and single-pass token logic for one source byte.
module stn_lexer #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic [7:0]              ch,
  input  logic                    eoi,
  output stn_pkg::tok_t           tok0,
  output logic [OFFSET_WIDTH-1:0] start0,
  output logic [OFFSET_WIDTH-1:0] len0,
  output stn_pkg::tok_t           tok1,
  output logic [OFFSET_WIDTH-1:0] start1,
  output logic [OFFSET_WIDTH-1:0] len1,
  output logic [1:0]              tok_cnt
);

  localparam logic [OFFSET_WIDTH-1:0] OFS_MAX = '1;
  localparam logic [OFFSET_WIDTH-1:0] LEN_ONE = OFFSET_WIDTH'(1);
  localparam logic [OFFSET_WIDTH-1:0] LEN_TWO = OFFSET_WIDTH'(2);

  stn_pkg::pend_kind_t     pk_r, pk_nxt;
  logic [OFFSET_WIDTH-1:0] pos_r, pos_nxt;
  logic [OFFSET_WIDTH-1:0] pstart_r, pstart_nxt;
  logic [OFFSET_WIDTH-1:0] plen_r, plen_nxt;
  logic [30:0]             acc_r, acc_nxt;
  logic                    sat_r, sat_nxt;

  logic [34:0]             acc_sum;
  logic                    acc_over;
  logic [30:0]             acc_grown;
  logic [OFFSET_WIDTH-1:0] plen_inc;

  logic                    comb2, cont, used;
  logic [3:0]              comb_code;
  logic                    e1v, e2v, e3v, e23v;
  stn_pkg::tok_t           e1, e2, e3, e23;
  logic [OFFSET_WIDTH-1:0] e1_len, e2_len, e3_len, e23_len;
  logic [OFFSET_WIDTH-1:0] e23_start;
  logic [4:0]              plook;

  stn_pkg::pend_kind_t     p2_pk;
  logic [OFFSET_WIDTH-1:0] p2_start, p2_len;
  logic [30:0]             p2_acc;
  logic                    p2_sat;

  // Token that a pending item gives when something ends it
  function automatic stn_pkg::tok_t flush_tok(input stn_pkg::pend_kind_t pk,
                                              input logic [30:0] acc,
                                              input logic sat);
    stn_pkg::tok_t t;
    t = '0;
    case (pk)
      stn_pkg::PK_IDENT:  t.kind = stn_pkg::KIND_IDENT;
      stn_pkg::PK_NUMBER: begin
        t.kind  = stn_pkg::KIND_NUMBER;
        t.value = acc;
        t.ovf   = sat;
      end
      stn_pkg::PK_LT: begin
        t.kind = stn_pkg::KIND_PUNCT;
        t.code = stn_pkg::PC_LT;
      end
      stn_pkg::PK_GT: begin
        t.kind = stn_pkg::KIND_PUNCT;
        t.code = stn_pkg::PC_GT;
      end
      stn_pkg::PK_COLON:  t.kind = stn_pkg::KIND_ERROR;
      default:            t = '0;
    endcase
    return t;
  endfunction

  // Grow the running number and length, saturating
  always_comb begin
    acc_sum  = (35'(acc_r) << 3) + (35'(acc_r) << 1) + 35'(ch[3:0]);
    acc_over = acc_sum > 35'(stn_pkg::VALUE_MAX);
    acc_grown = acc_over ? stn_pkg::VALUE_MAX : acc_sum[30:0];
    plen_inc = (plen_r == OFS_MAX) ? plen_r : plen_r + LEN_ONE;
  end

  // Resolve the pending token against this byte
  always_comb begin
    comb2     = 1'b0;
    cont      = 1'b0;
    comb_code = stn_pkg::PC_PLUS;
    case (pk_r)
      stn_pkg::PK_LT: begin
        if (ch == stn_pkg::CH_GT || ch == stn_pkg::CH_EQ) begin
          comb2     = 1'b1;
          comb_code = (ch == stn_pkg::CH_GT) ? stn_pkg::PC_NE : stn_pkg::PC_LE;
        end
      end
      stn_pkg::PK_GT: begin
        if (ch == stn_pkg::CH_EQ) begin
          comb2     = 1'b1;
          comb_code = stn_pkg::PC_GE;
        end
      end
      stn_pkg::PK_COLON: begin
        if (ch == stn_pkg::CH_EQ) begin
          comb2     = 1'b1;
          comb_code = stn_pkg::PC_ASSIGN;
        end
      end
      stn_pkg::PK_IDENT:  cont = stn_pkg::is_alpha(ch) || stn_pkg::is_digit(ch);
      stn_pkg::PK_NUMBER: cont = stn_pkg::is_digit(ch);
      default: begin
        comb2 = 1'b0;
        cont  = 1'b0;
      end
    endcase
    used = comb2 || cont;
    e1v  = comb2 || (!used && (pk_r != stn_pkg::PK_NONE));
    if (comb2) begin
      e1      = '0;
      e1.kind = stn_pkg::KIND_PUNCT;
      e1.code = comb_code;
      e1_len  = LEN_TWO;
    end else begin
      e1     = flush_tok(pk_r, acc_r, sat_r);
      e1_len = (pk_r == stn_pkg::PK_IDENT || pk_r == stn_pkg::PK_NUMBER) ?
               plen_r : LEN_ONE;
    end
  end

  // Start a new pending token or emit a one-byte token
  always_comb begin
    p2_pk    = stn_pkg::PK_NONE;
    p2_start = '0;
    p2_len   = '0;
    p2_acc   = '0;
    p2_sat   = 1'b0;
    e2v      = 1'b0;
    e2       = '0;
    e2_len   = LEN_ONE;
    plook    = stn_pkg::punct_lookup(ch);
    if (cont) begin
      p2_pk    = pk_r;
      p2_start = pstart_r;
      p2_len   = plen_inc;
      p2_acc   = (pk_r == stn_pkg::PK_NUMBER) ? acc_grown : acc_r;
      p2_sat   = sat_r || ((pk_r == stn_pkg::PK_NUMBER) && acc_over);
    end else if (!used && !stn_pkg::is_space(ch)) begin
      p2_start = pos_r;
      p2_len   = LEN_ONE;
      if (ch == stn_pkg::CH_LT) begin
        p2_pk = stn_pkg::PK_LT;
      end else if (ch == stn_pkg::CH_GT) begin
        p2_pk = stn_pkg::PK_GT;
      end else if (ch == stn_pkg::CH_COLON) begin
        p2_pk = stn_pkg::PK_COLON;
      end else if (stn_pkg::is_digit(ch)) begin
        p2_pk  = stn_pkg::PK_NUMBER;
        p2_acc = 31'(ch[3:0]);
      end else if (stn_pkg::is_alpha(ch)) begin
        p2_pk = stn_pkg::PK_IDENT;
      end else begin
        p2_start = '0;
        p2_len   = '0;
        e2v      = 1'b1;
        e2.kind  = plook[4] ? stn_pkg::KIND_PUNCT : stn_pkg::KIND_ERROR;
        e2.code  = plook[4] ? plook[3:0] : stn_pkg::PC_PLUS;
      end
    end
  end

  // Flush at end of input and order the tokens
  always_comb begin
    e3v    = eoi && (p2_pk != stn_pkg::PK_NONE);
    e3     = flush_tok(p2_pk, p2_acc, p2_sat);
    e3_len = (p2_pk == stn_pkg::PK_IDENT || p2_pk == stn_pkg::PK_NUMBER) ?
             p2_len : LEN_ONE;
    // a one-byte token leaves nothing pending, so e2 and e3 never coexist
    e23v      = e2v || e3v;
    e23       = e2v ? e2 : e3;
    e23_start = e2v ? pos_r : p2_start;
    e23_len   = e2v ? e2_len : e3_len;

    if (e1v) begin
      tok0    = e1;
      start0  = pstart_r;
      len0    = e1_len;
      tok_cnt = e23v ? 2'd2 : 2'd1;
    end else begin
      tok0    = e23;
      start0  = e23_start;
      len0    = e23_len;
      tok_cnt = e23v ? 2'd1 : 2'd0;
    end
    tok1      = e23;
    start1    = e23_start;
    len1      = e23_len;
    tok0.last = (tok_cnt == 2'd1);
    tok1.last = 1'b1;
  end

  // Advance pending state and byte position
  always_comb begin
    if (eoi) begin
      pk_nxt     = stn_pkg::PK_NONE;
      pstart_nxt = '0;
      plen_nxt   = '0;
      acc_nxt    = '0;
      sat_nxt    = 1'b0;
      pos_nxt    = '0;
    end else begin
      pk_nxt     = p2_pk;
      pstart_nxt = p2_start;
      plen_nxt   = p2_len;
      acc_nxt    = p2_acc;
      sat_nxt    = p2_sat;
      pos_nxt    = (pos_r == OFS_MAX) ? pos_r : pos_r + LEN_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pk_r     <= stn_pkg::PK_NONE;
      pos_r    <= '0;
      pstart_r <= '0;
      plen_r   <= '0;
      acc_r    <= '0;
      sat_r    <= 1'b0;
    end else if (step) begin
      pk_r     <= pk_nxt;
      pos_r    <= pos_nxt;
      pstart_r <= pstart_nxt;
      plen_r   <= plen_nxt;
      acc_r    <= acc_nxt;
      sat_r    <= sat_nxt;
    end
  end

  a_eoi_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    step && eoi |=> pos_r == '0 && pk_r == stn_pkg::PK_NONE)
    else $error("end of input did not restart the text");

  a_two_only_after_pending: assert property (@(posedge clk) disable iff (!rst_n)
    step && tok_cnt == 2'd2 |-> pk_r != stn_pkg::PK_NONE)
    else $error("two tokens without a pending token");

  a_number_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pk_r == stn_pkg::PK_NUMBER |-> acc_r <= stn_pkg::VALUE_MAX && plen_r != '0)
    else $error("pending number state out of range");

endmodule

>>> sv/stn_token_queue.sv
// Result queue holding up to four tokens, pushed up to two at a time.
module stn_token_queue #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [1:0]              push_n,
  input  stn_pkg::tok_t           tok0,
  input  logic [OFFSET_WIDTH-1:0] start0,
  input  logic [OFFSET_WIDTH-1:0] len0,
  input  stn_pkg::tok_t           tok1,
  input  logic [OFFSET_WIDTH-1:0] start1,
  input  logic [OFFSET_WIDTH-1:0] len1,
  input  logic                    pop,
  output logic                    room,
  output logic                    head_valid,
  output stn_pkg::tok_t           head_tok,
  output logic [OFFSET_WIDTH-1:0] head_start,
  output logic [OFFSET_WIDTH-1:0] head_len
);

  localparam int CW = $clog2(stn_pkg::QUEUE_DEPTH + 1);

  stn_pkg::tok_t           q_tok_r [stn_pkg::QUEUE_DEPTH];
  logic [OFFSET_WIDTH-1:0] q_start_r [stn_pkg::QUEUE_DEPTH];
  logic [OFFSET_WIDTH-1:0] q_len_r [stn_pkg::QUEUE_DEPTH];
  stn_pkg::tok_t           q_tok_nxt [stn_pkg::QUEUE_DEPTH];
  logic [OFFSET_WIDTH-1:0] q_start_nxt [stn_pkg::QUEUE_DEPTH];
  logic [OFFSET_WIDTH-1:0] q_len_nxt [stn_pkg::QUEUE_DEPTH];
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           base;

  // Shift out the head, then append new tokens behind the survivors
  always_comb begin
    base    = cnt_r - CW'(pop);
    room    = base <= CW'(stn_pkg::QUEUE_DEPTH - 2);
    cnt_nxt = base + CW'(push_n);
    for (int i = 0; i < stn_pkg::QUEUE_DEPTH; i++) begin
      if (pop && (i + 1 < stn_pkg::QUEUE_DEPTH)) begin
        q_tok_nxt[i]   = q_tok_r[i+1];
        q_start_nxt[i] = q_start_r[i+1];
        q_len_nxt[i]   = q_len_r[i+1];
      end else begin
        q_tok_nxt[i]   = q_tok_r[i];
        q_start_nxt[i] = q_start_r[i];
        q_len_nxt[i]   = q_len_r[i];
      end
      if (push_n != 2'd0 && base == CW'(i)) begin
        q_tok_nxt[i]   = tok0;
        q_start_nxt[i] = start0;
        q_len_nxt[i]   = len0;
      end
      if (push_n == 2'd2 && base + CW'(1) == CW'(i)) begin
        q_tok_nxt[i]   = tok1;
        q_start_nxt[i] = start1;
        q_len_nxt[i]   = len1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < stn_pkg::QUEUE_DEPTH; i++) begin
      q_tok_r[i]   <= q_tok_nxt[i];
      q_start_r[i] <= q_start_nxt[i];
      q_len_r[i]   <= q_len_nxt[i];
    end
  end

  assign head_valid = cnt_r != '0;
  assign head_tok   = q_tok_r[0];
  assign head_start = q_start_r[0];
  assign head_len   = q_len_r[0];

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(stn_pkg::QUEUE_DEPTH))
    else $error("token queue overfilled");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 2'd0 |-> room && push_n != 2'd3)
    else $error("token push without room");

  a_head_known: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> !$isunknown(head_tok))
    else $error("offered token has unknown bits");

endmodule

>>> sv/source_tokenizer_unit.sv
// Top level of the streaming source tokenizer.
//
// Usage: source bytes arrive on the in_ channel (in_ch, in_end_of_input),
// one transaction per byte; tokens leave on the out_ channel, one
// transaction per token, in text order. A transaction moves on a rising
// edge with valid high and stall low. in_end_of_input on a byte flushes the
// pending token after that byte and restarts offsets at 0 for the next text.
// out_last_of_run marks the final token caused by one byte.
// A byte is registered on acceptance and lexed from that register; its
// tokens are pushed into the result queue once the queue has room, and
// the registered queue head is offered on the out_ channel.
// Throughput: one byte per cycle while each byte yields at most one token
// and out_stall is low; the output channel moves one token per cycle, so
// bytes that yield two tokens are paid for by the four-entry result queue,
// and in_stall rises only when that queue cannot take two more tokens.
// When the receiver stalls, the queue fills and then the input stalls;
// nothing is dropped. Reset clears the pending token, the byte offset,
// the input valid flag and the queue; no clearing pass is needed.
module source_tokenizer_unit #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_ch,
  input  logic                    in_end_of_input,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_token_kind,
  output logic [3:0]              out_punct_code,
  output logic [OFFSET_WIDTH-1:0] out_start_offset,
  output logic [OFFSET_WIDTH-1:0] out_token_length,
  output logic [30:0]             out_number_value,
  output logic                    out_number_overflow,
  output logic                    out_last_of_run
);

  logic                    ivld_r;
  logic [7:0]              ch_r;
  logic                    eoi_r;
  logic                    room, step, pop, in_take;
  stn_pkg::tok_t           tok0, tok1, head_tok;
  logic [OFFSET_WIDTH-1:0] start0, len0, start1, len1;
  logic [1:0]              tok_cnt;
  logic [1:0]              push_n;

  // Lex the held byte when the queue can take its tokens
  assign step     = ivld_r && room;
  assign in_stall = ivld_r && !room;
  assign in_take  = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;
  assign push_n   = step ? tok_cnt : 2'd0;

  // Hold the accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r <= 1'b0;
    end else if (in_take) begin
      ivld_r <= 1'b1;
    end else if (step) begin
      ivld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ch_r  <= in_ch;
      eoi_r <= in_end_of_input;
    end
  end

  stn_lexer #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .ch      (ch_r),
    .eoi     (eoi_r),
    .tok0    (tok0),
    .start0  (start0),
    .len0    (len0),
    .tok1    (tok1),
    .start1  (start1),
    .len1    (len1),
    .tok_cnt (tok_cnt)
  );

  stn_token_queue #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (push_n),
    .tok0       (tok0),
    .start0     (start0),
    .len0       (len0),
    .tok1       (tok1),
    .start1     (start1),
    .len1       (len1),
    .pop        (pop),
    .room       (room),
    .head_valid (out_valid),
    .head_tok   (head_tok),
    .head_start (out_start_offset),
    .head_len   (out_token_length)
  );

  assign out_token_kind      = head_tok.kind;
  assign out_punct_code      = head_tok.code;
  assign out_number_value    = head_tok.value;
  assign out_number_overflow = head_tok.ovf;
  assign out_last_of_run     = head_tok.last;

endmodule

>>> sim/token_checker.sv
// Checker for the source tokenizer: predicts tokens from accepted bytes and compares results.
module token_checker #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [7:0]              in_ch,
  input  logic                    in_end_of_input,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [1:0]              out_token_kind,
  input  logic [3:0]              out_punct_code,
  input  logic [OFFSET_WIDTH-1:0] out_start_offset,
  input  logic [OFFSET_WIDTH-1:0] out_token_length,
  input  logic [30:0]             out_number_value,
  input  logic                    out_number_overflow,
  input  logic                    out_last_of_run,
  output int                      fail_count,
  output int                      tokens_waiting,
  output int                      tokens_checked,
  output int                      bytes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OFFSET_WIDTH-1:0] POS_MAX = '1;
  localparam logic [OFFSET_WIDTH-1:0] LEN_ONE = OFFSET_WIDTH'(1);
  localparam logic [OFFSET_WIDTH-1:0] LEN_TWO = OFFSET_WIDTH'(2);

  typedef struct {
    logic [1:0]              kind;
    logic [3:0]              code;
    logic [OFFSET_WIDTH-1:0] start;
    logic [OFFSET_WIDTH-1:0] len;
    logic [30:0]             value;
    logic                    ovf;
    logic                    last;
  } token_t;

  token_t expected_tokens[$];
  token_t step_tokens[$];
  token_t oldest;

  // Predictor state: offset of the next byte and the token still growing
  logic [OFFSET_WIDTH-1:0] text_pos;
  stn_pkg::pend_kind_t     run_kind;
  logic [OFFSET_WIDTH-1:0] run_start;
  logic [OFFSET_WIDTH-1:0] run_len;
  logic [30:0]             run_value;
  logic                    run_sat;

  int errors;
  int checked;
  int seen;

  function automatic bit byte_is_digit(input logic [7:0] c);
    return (c >= stn_pkg::CH_ZERO) && (c <= stn_pkg::CH_NINE);
  endfunction

  function automatic bit byte_is_letter(input logic [7:0] c);
    return ((c >= stn_pkg::CH_UA) && (c <= stn_pkg::CH_UZ)) ||
           ((c >= stn_pkg::CH_LA) && (c <= stn_pkg::CH_LZ));
  endfunction

  function automatic bit byte_is_blank(input logic [7:0] c);
    return (c == stn_pkg::CH_SPACE) || ((c >= stn_pkg::CH_TAB) && (c <= stn_pkg::CH_CR));
  endfunction

  function automatic void add_token(input logic [1:0] kind, input logic [3:0] code,
                                    input logic [OFFSET_WIDTH-1:0] start,
                                    input logic [OFFSET_WIDTH-1:0] len,
                                    input logic [30:0] value, input logic ovf);
    token_t t;
    t.kind  = kind;
    t.code  = code;
    t.start = start;
    t.len   = len;
    t.value = value;
    t.ovf   = ovf;
    t.last  = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void clear_run();
    run_kind  = stn_pkg::PK_NONE;
    run_start = '0;
    run_len   = '0;
    run_value = '0;
    run_sat   = 1'b0;
  endfunction

  function automatic void open_run(input stn_pkg::pend_kind_t kind,
                                   input logic [OFFSET_WIDTH-1:0] pos);
    run_kind  = kind;
    run_start = pos;
    run_len   = LEN_ONE;
    run_value = '0;
    run_sat   = 1'b0;
  endfunction

  // Emit whatever token is still growing, then forget it
  function automatic void close_run();
    case (run_kind)
      stn_pkg::PK_IDENT:
        add_token(stn_pkg::KIND_IDENT, stn_pkg::PC_PLUS, run_start, run_len, '0, 1'b0);
      stn_pkg::PK_NUMBER:
        add_token(stn_pkg::KIND_NUMBER, stn_pkg::PC_PLUS, run_start, run_len, run_value,
                  run_sat);
      stn_pkg::PK_LT:
        add_token(stn_pkg::KIND_PUNCT, stn_pkg::PC_LT, run_start, LEN_ONE, '0, 1'b0);
      stn_pkg::PK_GT:
        add_token(stn_pkg::KIND_PUNCT, stn_pkg::PC_GT, run_start, LEN_ONE, '0, 1'b0);
      stn_pkg::PK_COLON:
        add_token(stn_pkg::KIND_ERROR, stn_pkg::PC_PLUS, run_start, LEN_ONE, '0, 1'b0);
      default:   ;
    endcase
    clear_run();
  endfunction

  function automatic void lengthen_run();
    if (run_len != POS_MAX) run_len = run_len + 1'b1;
  endfunction

  // Work out the tokens that one byte causes and queue them in text order
  function automatic void predict_tokens(input logic [7:0] c, input logic eoi);
    logic [OFFSET_WIDTH-1:0] pos;
    logic [63:0]             wide;
    bit                      used;
    bit                      found;
    logic [3:0]              code;
    pos = text_pos;
    used = 0;
    found = 1;
    code = stn_pkg::PC_PLUS;
    step_tokens.delete();

    // Let the pending token absorb the byte if it can
    case (run_kind)
      stn_pkg::PK_LT: begin
        if (c == stn_pkg::CH_GT || c == stn_pkg::CH_EQ) begin
          add_token(stn_pkg::KIND_PUNCT,
                    (c == stn_pkg::CH_GT) ? stn_pkg::PC_NE : stn_pkg::PC_LE,
                    run_start, LEN_TWO, '0, 1'b0);
          clear_run();
          used = 1;
        end else begin
          close_run();
        end
      end
      stn_pkg::PK_GT, stn_pkg::PK_COLON: begin
        if (c == stn_pkg::CH_EQ) begin
          add_token(stn_pkg::KIND_PUNCT,
                    (run_kind == stn_pkg::PK_GT) ? stn_pkg::PC_GE : stn_pkg::PC_ASSIGN,
                    run_start, LEN_TWO, '0, 1'b0);
          clear_run();
          used = 1;
        end else begin
          close_run();
        end
      end
      stn_pkg::PK_IDENT: begin
        if (byte_is_letter(c) || byte_is_digit(c)) begin
          lengthen_run();
          used = 1;
        end else begin
          close_run();
        end
      end
      stn_pkg::PK_NUMBER: begin
        if (byte_is_digit(c)) begin
          wide = 64'(run_value) * 64'd10 + 64'(c - stn_pkg::CH_ZERO);
          if (wide > 64'(stn_pkg::VALUE_MAX)) begin
            run_value = stn_pkg::VALUE_MAX;
            run_sat = 1'b1;
          end else begin
            run_value = wide[30:0];
          end
          lengthen_run();
          used = 1;
        end else begin
          close_run();
        end
      end
      default: clear_run();
    endcase

    // Otherwise the byte starts something new
    if (!used && !byte_is_blank(c)) begin
      if (c == stn_pkg::CH_LT) begin
        open_run(stn_pkg::PK_LT, pos);
      end else if (c == stn_pkg::CH_GT) begin
        open_run(stn_pkg::PK_GT, pos);
      end else if (c == stn_pkg::CH_COLON) begin
        open_run(stn_pkg::PK_COLON, pos);
      end else if (byte_is_digit(c)) begin
        open_run(stn_pkg::PK_NUMBER, pos);
        run_value = 31'(c - stn_pkg::CH_ZERO);
      end else if (byte_is_letter(c)) begin
        open_run(stn_pkg::PK_IDENT, pos);
      end else begin
        case (c)
          stn_pkg::CH_PLUS:   code = stn_pkg::PC_PLUS;
          stn_pkg::CH_MINUS:  code = stn_pkg::PC_MINUS;
          stn_pkg::CH_STAR:   code = stn_pkg::PC_STAR;
          stn_pkg::CH_SLASH:  code = stn_pkg::PC_SLASH;
          stn_pkg::CH_LPAREN: code = stn_pkg::PC_LPAREN;
          stn_pkg::CH_RPAREN: code = stn_pkg::PC_RPAREN;
          stn_pkg::CH_EQ:     code = stn_pkg::PC_EQ;
          stn_pkg::CH_COMMA:  code = stn_pkg::PC_COMMA;
          stn_pkg::CH_DOT:    code = stn_pkg::PC_DOT;
          stn_pkg::CH_SEMI:   code = stn_pkg::PC_SEMI;
          default:            found = 0;
        endcase
        if (found) add_token(stn_pkg::KIND_PUNCT, code, pos, LEN_ONE, '0, 1'b0);
        else add_token(stn_pkg::KIND_ERROR, stn_pkg::PC_PLUS, pos, LEN_ONE, '0, 1'b0);
      end
    end

    // Flush on end of text and restart offsets; otherwise advance, saturating
    if (eoi) begin
      close_run();
      text_pos = '0;
    end else if (text_pos != POS_MAX) begin
      text_pos = text_pos + 1'b1;
    end

    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endtask

  // Track accepted transactions on both channels
  always @(posedge clk) begin
    if (!rst_n) begin
      text_pos = '0;
      clear_run();
      expected_tokens.delete();
    end else begin
      if (in_valid && !in_stall) begin
        predict_tokens(in_ch, in_end_of_input);
        seen++;
      end
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          $error("token with no expectation waiting: kind %0d offset %0d",
                 out_token_kind, out_start_offset);
          errors++;
        end else begin
          oldest = expected_tokens.pop_front();
          check_field("token_kind", 32'(oldest.kind), 32'(out_token_kind));
          check_field("punct_code", 32'(oldest.code), 32'(out_punct_code));
          check_field("start_offset", 32'(oldest.start), 32'(out_start_offset));
          check_field("token_length", 32'(oldest.len), 32'(out_token_length));
          check_field("number_value", 32'(oldest.value), 32'(out_number_value));
          check_field("number_overflow", 32'(oldest.ovf), 32'(out_number_overflow));
          check_field("last_of_run", 32'(oldest.last), 32'(out_last_of_run));
          checked++;
        end
      end
    end
    fail_count     <= errors;
    tokens_waiting <= expected_tokens.size();
    tokens_checked <= checked;
    bytes_seen     <= seen;
  end

endmodule

>>> sim/testbench.sv
// Top of the source tokenizer testbench: clock, reset, byte stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OFFSET_WIDTH = 16;
  localparam int STALL_MAX    = 17;
  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_BYTES = 600;
  localparam int LONG_RUN     = 40;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [7:0]              in_ch;
  logic                    in_end_of_input;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              out_token_kind;
  logic [3:0]              out_punct_code;
  logic [OFFSET_WIDTH-1:0] out_start_offset;
  logic [OFFSET_WIDTH-1:0] out_token_length;
  logic [30:0]             out_number_value;
  logic                    out_number_overflow;
  logic                    out_last_of_run;

  int fail_count;
  int tokens_waiting;
  int tokens_checked;
  int bytes_seen;
  int idle_cycles;
  int random_sent;
  bit tx_idle;
  bit rx_idle;

  source_tokenizer_unit #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_ch               (in_ch),
    .in_end_of_input     (in_end_of_input),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_token_kind      (out_token_kind),
    .out_punct_code      (out_punct_code),
    .out_start_offset    (out_start_offset),
    .out_token_length    (out_token_length),
    .out_number_value    (out_number_value),
    .out_number_overflow (out_number_overflow),
    .out_last_of_run     (out_last_of_run)
  );

  token_checker #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_ch               (in_ch),
    .in_end_of_input     (in_end_of_input),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_token_kind      (out_token_kind),
    .out_punct_code      (out_punct_code),
    .out_start_offset    (out_start_offset),
    .out_token_length    (out_token_length),
    .out_number_value    (out_number_value),
    .out_number_overflow (out_number_overflow),
    .out_last_of_run     (out_last_of_run),
    .fail_count          (fail_count),
    .tokens_waiting      (tokens_waiting),
    .tokens_checked      (tokens_checked),
    .bytes_seen          (bytes_seen)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Send one byte transaction, with an optional idle gap ahead of it
  task automatic send_byte(input logic [7:0] c, input logic eoi);
    int gap;
    gap = tx_idle ? $urandom_range(0, STALL_MAX) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_ch           <= c;
    in_end_of_input <= eoi;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], close && (i == s.len() - 1));
  endtask

  // Drop valid, then hold the sender until every predicted token has been taken
  task automatic wait_for_tokens();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tokens_waiting != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? stn_pkg::CH_LA + 8'(r) : stn_pkg::CH_UA + 8'(r - 26);
  endfunction

  function automatic logic [7:0] pick_digit();
    return stn_pkg::CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Build one random lexeme (or noise) and send it; end of text now and then
  task automatic send_fragment();
    logic [7:0] frag[$];
    string      singles;
    string      pairs[4];
    int         sel;
    int         n;
    bit         close;
    singles = "+-*/()=<>,.;:";
    pairs = '{"<>", "<=", ">=", ":="};
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      frag.push_back(pick_letter());
      n = $urandom_range(0, 6);
      repeat (n) frag.push_back(($urandom_range(0, 2) == 0) ? pick_digit() : pick_letter());
    end else if (sel < 45) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 4);
      repeat (n) frag.push_back(pick_digit());
    end else if (sel < 62) begin
      frag.push_back(singles[$urandom_range(0, singles.len() - 1)]);
    end else if (sel < 72) begin
      n = $urandom_range(0, 3);
      frag.push_back(pairs[n][0]);
      frag.push_back(pairs[n][1]);
    end else if (sel < 90) begin
      n = $urandom_range(0, 6);
      frag.push_back((n == 6) ? stn_pkg::CH_SPACE : stn_pkg::CH_TAB + 8'(n));
    end else begin
      frag.push_back(8'($urandom_range(0, 255)));
    end
    close = ($urandom_range(0, 19) == 0);
    foreach (frag[i]) send_byte(frag[i], close && (i == frag.size() - 1));
    random_sent += frag.size();
  endtask

  // Receiver: draw a stall length for every token, then take it
  initial begin
    int gap;
    out_stall = 1'b0;
    forever begin
      gap = rx_idle ? $urandom_range(0, STALL_MAX) : 0;
      @(negedge clk);
      out_stall <= (gap != 0);
      if (gap != 0) begin
        repeat (gap) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_ch           = '0;
    in_end_of_input = 1'b0;
    random_sent     = 0;
    tx_idle         = 1'b1;
    rx_idle         = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every punctuator, two-byte forms, lone colon, number then letter
    send_text("+-*/()=< >,.;", 1'b1);
    send_text("x9<>1<=Z>=:=:q 12ab", 1'b0);
    // Unknown bytes at both ends of the range, a tab, and a dangling '<' flushed
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(stn_pkg::CH_TAB, 1'b0);
    send_byte(stn_pkg::CH_LT, 1'b1);
    // Value just past the saturation point
    send_text("2147483648", 1'b1);
    wait_for_tokens();

    // Random text, cycling through idle patterns on each side
    for (int phase = 0; phase < 4; phase++) begin
      tx_idle = (phase == 0) || (phase == 1);
      rx_idle = (phase == 0) || (phase == 2);
      while (random_sent < (phase + 1) * RANDOM_BYTES / 4) send_fragment();
      wait_for_tokens();
    end

    // Long identifier sent back to back with neither side idling
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_byte(stn_pkg::CH_LA, 1'b0);
    repeat (LONG_RUN) send_byte(stn_pkg::CH_LA + 8'd1, 1'b0);
    send_text(" +7", 1'b1);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_text("ok;", 1'b1);

    @(negedge clk);
    in_valid <= 1'b0;
    wait_for_tokens();
    repeat (10) @(posedge clk);

    $display("tb: %0d bytes sent, %0d tokens checked", bytes_seen, tokens_checked);
    $display("tb: covered all token kinds, random stalls, number saturation and burst input");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
